// ===== hw/rtl/ranked_sequence_store_unit_macros.svh =====
// Assertion macros for the ranked sequence store unit.
`ifndef RANKED_SEQUENCE_STORE_UNIT_MACROS_SVH
`define RANKED_SEQUENCE_STORE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSS_ASSERT_SAME(lbl, ante, cons, msg)
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rss_pkg.sv =====
// Types and constants of the ranked sequence store unit.
`timescale 1ns / 1ps
package rss_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int FUNC_W       = 2;
    localparam int POS_W        = 7;
    localparam int BYTE_W       = 8;
    localparam int STAT_W       = 2;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_ERASE  = 2'd1,
        FUNC_GET    = 2'd2,
        FUNC_DUMP   = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANK  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;
endpackage

// ===== hw/rtl/ranked_sequence_store_unit.sv =====
// Ranked sequence store: position-addressed byte list with insert, erase, get and dump.
// Steps: errors and empty dump go straight to the response; get reads, then responds;
// insert shifts later entries up, then writes; erase shifts them down; dump streams all.
// Throughput: one item at a time; the next item is taken the cycle after the last result
// is loaded into the output register. Reset (rst_n low, asynchronous) empties the store
// and clears the handshake state; entry contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "ranked_sequence_store_unit_macros.svh"
module ranked_sequence_store_unit #(
    parameter int CAPACITY = rss_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [6:0] position, [14:7] byte_in, [15] zero
    input  logic [rss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] func
    input  logic [rss_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] byte_out
    output logic [rss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [rss_pkg::STAT_W-1:0]       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import rss_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_SH,
        S_INS_PUT,
        S_ERA_SH,
        S_GET_WAIT,
        S_DUMP,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    func_t               func_reg, func_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    status_t             resp_status_reg, resp_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_byte_reg, m_byte_next;
    status_t             m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;

    logic [BYTE_W-1:0]   mem [CAPACITY];
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic                out_free;
    logic [7:0]          pos8;
    logic [7:0]          cnt8;
    logic [ADDR_W-1:0]   pos_addr;
    logic [ADDR_W-1:0]   cnt_m1;
    logic                dump_last;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign pos8      = {1'b0, pos_reg};
    assign cnt8      = 8'(count_reg);
    assign pos_addr  = ADDR_W'(pos_reg - 7'd1);
    assign cnt_m1    = ADDR_W'(count_reg - CNT_W'(1));
    assign dump_last = (idx_reg == cnt_m1);

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        pos_next         = pos_reg;
        byte_next        = byte_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        resp_status_next = resp_status_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_byte_next      = m_byte_reg;
        m_status_next    = m_status_reg;
        m_last_next      = m_last_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = byte_reg;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next  = func_t'(s_axis_tuser);
                    pos_next   = s_axis_tdata[6:0];
                    byte_next  = s_axis_tdata[14:7];
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next       = S_RESP;
                resp_status_next = STAT_OK;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (pos_reg == '0 || pos8 > cnt8 + 8'd1)
                            resp_status_next = STAT_RANK;
                        else if (count_reg == CNT_W'(CAPACITY))
                            resp_status_next = STAT_FULL;
                        else if (pos8 <= cnt8)
                        begin
                            // move entries from the tail down to the insert rank
                            idx_next   = cnt_m1;
                            mem_re     = 1'b1;
                            mem_raddr  = cnt_m1;
                            state_next = S_INS_SH;
                        end
                        else
                            state_next = S_INS_PUT;
                    end
                    FUNC_ERASE:
                    begin
                        if (pos_reg == '0 || pos8 > cnt8)
                            resp_status_next = STAT_RANK;
                        else if (pos8 < cnt8)
                        begin
                            idx_next   = ADDR_W'(pos_reg);
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(pos_reg);
                            state_next = S_ERA_SH;
                        end
                        else
                            count_next = count_reg - CNT_W'(1);
                    end
                    FUNC_GET:
                    begin
                        if (pos_reg == '0 || pos8 > cnt8)
                            resp_status_next = STAT_RANK;
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = pos_addr;
                            state_next = S_GET_WAIT;
                        end
                    end
                    FUNC_DUMP:
                    begin
                        if (count_reg == '0)
                            resp_status_next = STAT_EMPTY;
                        else
                        begin
                            idx_next   = '0;
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            state_next = S_DUMP;
                        end
                    end
                    default:
                        resp_status_next = STAT_RANK;
                endcase
            end
            S_INS_SH:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + ADDR_W'(1);
                mem_wdata = rd_data_reg;
                if (idx_reg == pos_addr)
                    state_next = S_INS_PUT;
                else
                begin
                    idx_next  = idx_reg - ADDR_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - ADDR_W'(1);
                end
            end
            S_INS_PUT:
            begin
                mem_we           = 1'b1;
                mem_waddr        = pos_addr;
                mem_wdata        = byte_reg;
                count_next       = count_reg + CNT_W'(1);
                resp_status_next = STAT_OK;
                state_next       = S_RESP;
            end
            S_ERA_SH:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - ADDR_W'(1);
                mem_wdata = rd_data_reg;
                if (idx_reg == cnt_m1)
                begin
                    count_next       = count_reg - CNT_W'(1);
                    resp_status_next = STAT_OK;
                    state_next       = S_RESP;
                end
                else
                begin
                    idx_next  = idx_reg + ADDR_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + ADDR_W'(1);
                end
            end
            S_GET_WAIT:
                state_next = S_RESP;
            S_DUMP:
            begin
                // hold the read word until the output register frees up
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_byte_next   = rd_data_reg;
                    m_status_next = STAT_OK;
                    m_last_next   = dump_last;
                    if (dump_last)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next  = idx_reg + ADDR_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + ADDR_W'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_byte_next   = (func_reg == FUNC_GET && resp_status_reg == STAT_OK) ?
                                    rd_data_reg : '0;
                    m_status_next = resp_status_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
            func_reg        <= FUNC_INSERT;
            pos_reg         <= '0;
            byte_reg        <= '0;
            idx_reg         <= '0;
            resp_status_reg <= STAT_OK;
            m_byte_reg      <= '0;
            m_status_reg    <= STAT_OK;
            m_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            m_valid_reg     <= m_valid_next;
            func_reg        <= func_next;
            pos_reg         <= pos_next;
            byte_reg        <= byte_next;
            idx_reg         <= idx_next;
            resp_status_reg <= resp_status_next;
            m_byte_reg      <= m_byte_next;
            m_status_reg    <= m_status_next;
            m_last_reg      <= m_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_byte_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

    `RSS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `RSS_ASSERT_NEXT(a_count_step, 1'b1, count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1) || count_reg == $past(count_reg) - CNT_W'(1), "count jumped")
    `RSS_ASSERT_NEXT(a_dump_count, state_reg == S_DUMP, $stable(count_reg), "count changed in dump")
    `RSS_ASSERT_SAME(a_write_busy, mem_we, state_reg != S_IDLE, "memory write while idle")
endmodule

// ===== tb/ranked_sequence_store_unit_tb.sv =====
// Self-checking testbench for the ranked sequence store unit.
`timescale 1ns / 1ps
module ranked_sequence_store_unit_tb;
    import rss_pkg::*;

    localparam int CAP            = CAPACITY_DEF;
    localparam int MAX_RANK       = CAP + 1;
    localparam int RANDOM_ITEMS   = 320;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int HOLD_CYCLES    = 400;

    typedef struct {
        func_t      op;
        logic [6:0] rank;
        logic [7:0] value;
    } request_t;

    typedef struct {
        logic [7:0] data;
        status_t    code;
        logic       tail;
    } outcome_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // sequence contents as the block should hold them
    logic [7:0]             seq_bytes [CAP];
    int                     seq_len = 0;
    outcome_t               expected_results [$];

    request_t               pending [$];
    request_t               offered;
    int                     planned_len = 0;
    int                     total_items = 0;
    int                     accepted_cnt = 0;
    int                     fail_cnt = 0;
    int                     src_gap = 0;
    int                     sink_gap = 0;
    logic                   src_go;
    logic                   sink_rdy;
    logic                   calm = 1'b0;
    logic                   sink_hold = 1'b0;

    ranked_sequence_store_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic void push_result(logic [7:0] data, status_t code, logic tail);
        outcome_t o;
        o.data = data;
        o.code = code;
        o.tail = tail;
        expected_results.push_back(o);
    endfunction

    // Apply one request to the sequence and queue the results it produces.
    function automatic void apply_request(request_t req);
        int r;
        int i;
        r = req.rank;
        case (req.op)
            FUNC_INSERT:
            begin
                if (r < 1 || r > seq_len + 1)
                    push_result(8'h00, STAT_RANK, 1'b1);
                else if (seq_len >= CAP)
                    push_result(8'h00, STAT_FULL, 1'b1);
                else
                begin
                    for (i = seq_len; i > r - 1; i--)
                        seq_bytes[i] = seq_bytes[i-1];
                    seq_bytes[r-1] = req.value;
                    seq_len++;
                    push_result(8'h00, STAT_OK, 1'b1);
                end
            end
            FUNC_ERASE:
            begin
                if (r < 1 || r > seq_len)
                    push_result(8'h00, STAT_RANK, 1'b1);
                else
                begin
                    for (i = r - 1; i + 1 < seq_len; i++)
                        seq_bytes[i] = seq_bytes[i+1];
                    seq_len--;
                    push_result(8'h00, STAT_OK, 1'b1);
                end
            end
            FUNC_GET:
            begin
                if (r < 1 || r > seq_len)
                    push_result(8'h00, STAT_RANK, 1'b1);
                else
                    push_result(seq_bytes[r-1], STAT_OK, 1'b1);
            end
            default:
            begin
                if (seq_len == 0)
                    push_result(8'h00, STAT_EMPTY, 1'b1);
                else
                    for (i = 0; i < seq_len; i++)
                        push_result(seq_bytes[i], STAT_OK, i + 1 == seq_len);
            end
        endcase
    endfunction

    // Queue a request and track the length it leaves behind.
    function automatic void add_request(func_t op, int rank, int value);
        request_t req;
        req.op    = op;
        req.rank  = rank[6:0];
        req.value = value[7:0];
        pending.push_back(req);
        total_items++;
        if (op == FUNC_INSERT && rank >= 1 && rank <= planned_len + 1 && planned_len < CAP)
            planned_len++;
        else if (op == FUNC_ERASE && rank >= 1 && rank <= planned_len)
            planned_len--;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hold off the sink long enough for the block to back up its input.
    initial
    begin
        wait (rst_n === 1'b1);
        wait (accepted_cnt >= 60);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Driver: present queued items, idle in short random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            src_go = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(offered);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending.size() != 0 && !calm && $urandom_range(0, 99) < 10)
                    src_gap = $urandom_range(0, 5);
                else if (pending.size() != 0)
                begin
                    offered = pending.pop_front();
                    s_axis_tdata <= {1'b0, offered.value, offered.rank};
                    s_axis_tuser <= offered.op;
                    src_go = 1'b1;
                end
                s_axis_tvalid <= src_go;
            end
            calm <= (pending.size() < 30) || (accepted_cnt >= 100 && accepted_cnt < 140);
        end
    end

    // Monitor: check every result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: data %02h status %0d last %0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_cnt++;
                end
                else
                begin
                    outcome_t exp_o;
                    exp_o = expected_results.pop_front();
                    if (m_axis_tdata !== exp_o.data)
                    begin
                        $display("%0t: byte_out mismatch: expected %02h, actual %02h",
                                 $time, exp_o.data, m_axis_tdata);
                        fail_cnt++;
                    end
                    if (m_axis_tuser !== exp_o.code)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, exp_o.code, m_axis_tuser);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== exp_o.tail)
                    begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, exp_o.tail, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                sink_rdy = 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 10)
            begin
                sink_gap = $urandom_range(0, 5);
                sink_rdy = 1'b0;
            end
            else
                sink_rdy = 1'b1;
            m_axis_tready <= sink_rdy && !sink_hold;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int     n;
        int     pick;
        int     rank;
        logic   grow;
        func_t  op;

        // empty store corners
        add_request(FUNC_DUMP, 0, 8'h00);
        add_request(FUNC_GET, 1, 8'h00);
        add_request(FUNC_ERASE, 0, 8'hFF);
        add_request(FUNC_INSERT, 0, 8'h11);
        add_request(FUNC_INSERT, 2, 8'h22);
        // insert at front, end and middle
        add_request(FUNC_INSERT, 1, 8'hFF);
        add_request(FUNC_INSERT, 2, 8'h00);
        add_request(FUNC_INSERT, 1, 8'h5A);
        add_request(FUNC_INSERT, 3, 8'hA5);
        add_request(FUNC_INSERT, MAX_RANK, 8'h7F);
        add_request(FUNC_GET, 0, 8'h80);
        add_request(FUNC_GET, 4, 8'h00);
        add_request(FUNC_GET, 5, 8'h00);
        add_request(FUNC_GET, CAP, 8'h00);
        add_request(FUNC_DUMP, MAX_RANK, 8'hFF);
        add_request(FUNC_ERASE, 1, 8'h00);
        add_request(FUNC_ERASE, 3, 8'h00);
        add_request(FUNC_ERASE, 3, 8'h00);
        add_request(FUNC_GET, 1, 8'hFF);
        add_request(FUNC_ERASE, MAX_RANK, 8'h00);
        add_request(FUNC_DUMP, 1, 8'h00);

        grow = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (grow && planned_len == CAP)
            begin
                // full store: good rank, top rank, bad rank on full
                add_request(FUNC_INSERT, MAX_RANK, $urandom_range(0, 255));
                add_request(FUNC_INSERT, 0, $urandom_range(0, 255));
                add_request(FUNC_INSERT, $urandom_range(1, CAP), $urandom_range(0, 255));
                add_request(FUNC_GET, CAP, $urandom_range(0, 255));
                add_request(FUNC_GET, MAX_RANK, $urandom_range(0, 255));
                add_request(FUNC_DUMP, $urandom_range(0, MAX_RANK), $urandom_range(0, 255));
                grow = 1'b0;
            end
            else if (!grow && planned_len == 0)
            begin
                add_request(FUNC_ERASE, $urandom_range(0, MAX_RANK), $urandom_range(0, 255));
                add_request(FUNC_GET, $urandom_range(0, MAX_RANK), $urandom_range(0, 255));
                add_request(FUNC_DUMP, $urandom_range(0, MAX_RANK), $urandom_range(0, 255));
                grow = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (grow)
                op = pick < 80 ? FUNC_INSERT : pick < 88 ? FUNC_GET :
                     pick < 96 ? FUNC_ERASE : FUNC_DUMP;
            else
                op = pick < 65 ? FUNC_ERASE : pick < 82 ? FUNC_GET :
                     pick < 96 ? FUNC_INSERT : FUNC_DUMP;
            if (op == FUNC_DUMP || $urandom_range(0, 99) < 12)
                rank = $urandom_range(0, MAX_RANK);
            else if (op == FUNC_INSERT)
                rank = $urandom_range(1, planned_len + 1);
            else if (planned_len == 0)
                rank = $urandom_range(0, MAX_RANK);
            else
                rank = $urandom_range(1, planned_len);
            add_request(op, rank, $urandom_range(0, 255));
        end

        wait (rst_n === 1'b1);
        while (accepted_cnt != total_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
